FILE: sv/fpea_pkg.sv
// Package: request/result types, codes and controller/datapath interface structs.
package fpea_pkg;

  typedef struct packed {
    logic        operation;
    logic [15:0] block_size;
    logic [15:0] block_start;
  } in_req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] alloc_address;
    logic [4:0]  free_extents;
  } out_res_t;

  localparam logic       OP_ALLOC = 1'b0;
  localparam logic       OP_FREE  = 1'b1;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NOFIT = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  localparam int         CFG_IDX_W      = 1;
  localparam logic [0:0] REG_FIT_POLICY = 1'd0;
  localparam logic [0:0] REG_POOL_SIZE  = 1'd1;
  localparam logic [15:0] POOL_RESET    = 16'd4096;

  typedef struct packed {
    logic latch;
    logic init;
    logic sc_rd;
    logic sc_cmp;
    logic al_upd;
    logic rm_rd;
    logic rm_wr;
    logic fr_app;
    logic co_ird;
    logic co_ild;
    logic co_jrd;
    logic co_jcmp;
  } ctl_cmd_t;

  typedef struct packed {
    logic scan_end;
    logic found;
    logic pick_empty;
    logic rm_end;
    logic free_stop;
    logic i_end;
    logic j_end;
    logic merge;
  } dp_sts_t;

endpackage

FILE: sv/fpea_dp.sv
// Datapath: extent table memory, scan/pick registers, coalesce and removal logic.
module fpea_dp import fpea_pkg::*; #(
  parameter int MAX_EXTENTS = 16,
  parameter int ADDR_BITS   = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  in_req_t              in_req,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_wdata,
  input  ctl_cmd_t             cmd,
  output dp_sts_t              sts,
  output out_res_t             res
);

  localparam int AW = ADDR_BITS;
  localparam int IW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int CW = $clog2(MAX_EXTENTS + 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(MAX_EXTENTS);

  logic [2*AW-1:0] mem [MAX_EXTENTS];
  logic [2*AW-1:0] rdata_r;

  in_req_t       req_r;
  logic [1:0]    pol_r;
  logic [15:0]   pool_r;
  logic [CW-1:0] cnt_r, k_r, m_r, i_r, j_r;
  logic          found_r;
  logic [IW-1:0] pick_r;
  logic [AW-1:0] pick_start_r, pick_size_r, si_r, zi_r;
  logic [1:0]    status_r;
  logic [AW-1:0] addr_r;

  logic [AW-1:0] size_a, start_a, rs, rz;
  logic [AW:0]   zsum;
  logic          fits, m1, m2, first_fit, take, pool_wr;
  logic          we, re;
  logic [IW-1:0] waddr, raddr;
  logic [2*AW-1:0] wdata;
  logic [AW-1:0] pool_src;

  assign size_a    = AW'(req_r.block_size);
  assign start_a   = AW'(req_r.block_start);
  assign rs        = rdata_r[2*AW-1:AW];
  assign rz        = rdata_r[AW-1:0];
  assign first_fit = (pol_r != POL_BEST) && (pol_r != POL_WORST);
  assign pool_wr   = cfg_we && (cfg_index == REG_POOL_SIZE);
  assign pool_src  = cmd.init ? AW'(pool_r) : AW'(cfg_wdata);

  assign zsum = {1'b0, zi_r} + {1'b0, rz};
  assign fits = !zsum[AW];
  assign m1   = fits && (({1'b0, si_r} + {1'b0, zi_r}) == {1'b0, rs});
  assign m2   = fits && (({1'b0, rs} + {1'b0, rz}) == {1'b0, si_r});

  always_comb begin
    take = 1'b0;
    if (rz >= size_a) begin
      if (!found_r) take = 1'b1;
      else if (pol_r == POL_BEST && rz < pick_size_r) take = 1'b1;
      else if (pol_r == POL_WORST && rz > pick_size_r) take = 1'b1;
    end
  end

  always_comb begin
    sts.scan_end   = (k_r >= cnt_r) || (found_r && first_fit);
    sts.found      = found_r;
    sts.pick_empty = (pick_size_r == size_a);
    sts.rm_end     = ({1'b0, m_r} + 1'b1) >= {1'b0, cnt_r};
    sts.free_stop  = (size_a == '0) || (cnt_r >= CNT_MAX);
    sts.i_end      = i_r >= cnt_r;
    sts.j_end      = j_r >= cnt_r;
    sts.merge      = m1 || m2;
  end

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    re    = 1'b0;
    raddr = '0;
    if (cmd.init || pool_wr) begin
      we    = 1'b1;
      wdata = {{AW{1'b0}}, pool_src};
    end else if (cmd.al_upd && found_r && !sts.pick_empty) begin
      we    = 1'b1;
      waddr = pick_r;
      wdata = {pick_start_r + size_a, pick_size_r - size_a};
    end else if (cmd.rm_wr) begin
      we    = 1'b1;
      waddr = m_r[IW-1:0];
      wdata = rdata_r;
    end else if (cmd.fr_app && !sts.free_stop) begin
      we    = 1'b1;
      waddr = cnt_r[IW-1:0];
      wdata = {start_a, size_a};
    end else if (cmd.co_jcmp && sts.merge) begin
      we    = 1'b1;
      waddr = i_r[IW-1:0];
      wdata = {m1 ? si_r : rs, zsum[AW-1:0]};
    end
    if (cmd.sc_rd && !sts.scan_end) begin
      re    = 1'b1;
      raddr = k_r[IW-1:0];
    end else if (cmd.rm_rd && !sts.rm_end) begin
      re    = 1'b1;
      raddr = IW'(m_r + 1'b1);
    end else if (cmd.co_ird && !sts.i_end) begin
      re    = 1'b1;
      raddr = i_r[IW-1:0];
    end else if (cmd.co_jrd && !sts.j_end) begin
      re    = 1'b1;
      raddr = j_r[IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pol_r    <= '0;
      pool_r   <= POOL_RESET;
      cnt_r    <= '0;
      found_r  <= 1'b0;
      status_r <= ST_OK;
      addr_r   <= '0;
    end else begin
      if (cfg_we && cfg_index == REG_FIT_POLICY) pol_r <= cfg_wdata[1:0];
      if (pool_wr) pool_r <= cfg_wdata;
      if (cmd.init || pool_wr) cnt_r <= (pool_src == '0) ? '0 : CW'(1);
      if (cmd.latch) begin
        req_r    <= in_req;
        k_r      <= '0;
        found_r  <= 1'b0;
        status_r <= ST_OK;
        addr_r   <= '0;
      end
      if (cmd.sc_cmp) begin
        k_r <= k_r + 1'b1;
        if (take) begin
          found_r      <= 1'b1;
          pick_r       <= k_r[IW-1:0];
          pick_start_r <= rs;
          pick_size_r  <= rz;
        end
      end
      if (cmd.al_upd) begin
        if (found_r) begin
          addr_r <= pick_start_r;
          m_r    <= CW'(pick_r);
        end else begin
          status_r <= ST_NOFIT;
        end
      end
      if (cmd.rm_rd && sts.rm_end) cnt_r <= cnt_r - 1'b1;
      if (cmd.rm_wr) m_r <= m_r + 1'b1;
      if (cmd.fr_app) begin
        i_r <= '0;
        if (size_a != '0) begin
          if (cnt_r >= CNT_MAX) status_r <= ST_FULL;
          else cnt_r <= cnt_r + 1'b1;
        end
      end
      if (cmd.co_ild) begin
        si_r <= rs;
        zi_r <= rz;
        j_r  <= i_r + 1'b1;
      end
      if (cmd.co_jrd && sts.j_end) i_r <= i_r + 1'b1;
      if (cmd.co_jcmp) begin
        if (sts.merge) begin
          zi_r <= zsum[AW-1:0];
          if (!m1) si_r <= rs;
          m_r <= j_r;
          j_r <= i_r + 1'b1;
        end else begin
          j_r <= j_r + 1'b1;
        end
      end
    end
  end

  assign res.status        = status_r;
  assign res.alloc_address = 16'(addr_r);
  assign res.free_extents  = 5'(cnt_r);

endmodule

FILE: sv/fpea_ctrl.sv
// Controller: one-hot sequencer for init, scan, update, removal, append and coalesce steps.
module fpea_ctrl import fpea_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  logic     op,
  input  dp_sts_t  sts,
  output ctl_cmd_t cmd,
  output logic     busy,
  output logic     done
);

  typedef enum logic [12:0] {
    S_IDLE    = 13'b0000000000001,
    S_INIT    = 13'b0000000000010,
    S_SC_RD   = 13'b0000000000100,
    S_SC_CMP  = 13'b0000000001000,
    S_AL_UPD  = 13'b0000000010000,
    S_RM_RD   = 13'b0000000100000,
    S_RM_WR   = 13'b0000001000000,
    S_FR_APP  = 13'b0000010000000,
    S_CO_IRD  = 13'b0000100000000,
    S_CO_ILD  = 13'b0001000000000,
    S_CO_JRD  = 13'b0010000000000,
    S_CO_JCMP = 13'b0100000000000,
    S_DONE    = 13'b1000000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   ret_r, ret_nxt;

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    case (state_r)
      S_IDLE: begin
        if (start) state_nxt = (op == OP_ALLOC) ? S_SC_RD : S_FR_APP;
      end
      S_INIT:   state_nxt = S_IDLE;
      S_SC_RD:  state_nxt = sts.scan_end ? S_AL_UPD : S_SC_CMP;
      S_SC_CMP: state_nxt = S_SC_RD;
      S_AL_UPD: begin
        if (sts.found && sts.pick_empty) begin
          state_nxt = S_RM_RD;
          ret_nxt   = 1'b0;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_RM_RD: begin
        if (sts.rm_end) state_nxt = ret_r ? S_CO_JRD : S_DONE;
        else state_nxt = S_RM_WR;
      end
      S_RM_WR:  state_nxt = S_RM_RD;
      S_FR_APP: state_nxt = sts.free_stop ? S_DONE : S_CO_IRD;
      S_CO_IRD: state_nxt = sts.i_end ? S_DONE : S_CO_ILD;
      S_CO_ILD: state_nxt = S_CO_JRD;
      S_CO_JRD: state_nxt = sts.j_end ? S_CO_IRD : S_CO_JCMP;
      S_CO_JCMP: begin
        if (sts.merge) begin
          state_nxt = S_RM_RD;
          ret_nxt   = 1'b1;
        end else begin
          state_nxt = S_CO_JRD;
        end
      end
      S_DONE:   state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
      ret_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
    end
  end

  always_comb begin
    cmd.latch   = (state_r == S_IDLE) && start;
    cmd.init    = state_r == S_INIT;
    cmd.sc_rd   = state_r == S_SC_RD;
    cmd.sc_cmp  = state_r == S_SC_CMP;
    cmd.al_upd  = state_r == S_AL_UPD;
    cmd.rm_rd   = state_r == S_RM_RD;
    cmd.rm_wr   = state_r == S_RM_WR;
    cmd.fr_app  = state_r == S_FR_APP;
    cmd.co_ird  = state_r == S_CO_IRD;
    cmd.co_ild  = state_r == S_CO_ILD;
    cmd.co_jrd  = state_r == S_CO_JRD;
    cmd.co_jcmp = state_r == S_CO_JCMP;
  end

  assign busy = state_r != S_IDLE;
  assign done = state_r == S_DONE;

endmodule

FILE: sv/fit_policy_extent_allocator.sv
// Alloc: scans the extents, updates the pick, and shifts the table down when the pick empties.
// Free: appends the extent unless its size is zero or the table is full, then coalesces pairs with shifts.
// One request at a time; the next is taken in the idle cycle after the strobe.
// out_valid strobes one cycle per request; the receiver cannot stall.
// Synchronous active-low reset; an init state after reset loads the single extent (0, 4096).
module fit_policy_extent_allocator import fpea_pkg::*; #(
  parameter int MAX_EXTENTS = 16,
  parameter int ADDR_BITS   = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_req_t              in_req,
  output logic                 out_valid,
  output out_res_t             out_res,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [15:0]          cfg_wdata
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  fpea_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .op    (in_req.operation),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (out_valid)
  );

  fpea_dp #(
    .MAX_EXTENTS (MAX_EXTENTS),
    .ADDR_BITS   (ADDR_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_req    (in_req),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .sts       (sts),
    .res       (out_res)
  );

endmodule

FILE: tb/fit_policy_extent_allocator_test.sv
// Testbench for the fit-policy extent allocator: random and directed requests against a predictor.
`timescale 1ns / 1ps

module fit_policy_extent_allocator_test;
  import fpea_pkg::*;

  localparam int NEXT = 16;

  class alloc_scoreboard;
    logic [1:0]  policy;
    logic [15:0] pool;
    logic [16:0] ext_start [NEXT];
    logic [16:0] ext_size  [NEXT];
    int          n_ext;
    out_res_t    pending [$];
    int          mismatches;

    function void init_table();
      for (int k = 0; k < NEXT; k++) begin
        ext_start[k] = '0;
        ext_size[k]  = '0;
      end
      if (pool == 16'd0) n_ext = 0;
      else begin
        ext_size[0] = {1'b0, pool};
        n_ext = 1;
      end
    endfunction

    function void reset_state();
      policy = 2'd0;
      pool = POOL_RESET;
      mismatches = 0;
      init_table();
    endfunction

    function void write_reg(logic [0:0] idx, logic [15:0] val);
      if (idx == REG_FIT_POLICY) policy = val[1:0];
      else begin
        pool = val;
        init_table();
      end
    endfunction

    function void drop(int k);
      for (int m = k; m + 1 < n_ext; m++) begin
        ext_start[m] = ext_start[m + 1];
        ext_size[m]  = ext_size[m + 1];
      end
      n_ext--;
    endfunction

    function void merge_all();
      int j;
      logic [17:0] si, zi, sj, zj;
      bit fits;
      for (int i = 0; i < n_ext; i++) begin
        j = i + 1;
        while (j < n_ext) begin
          si = ext_start[i]; zi = ext_size[i];
          sj = ext_start[j]; zj = ext_size[j];
          fits = (zi + zj) <= 18'hFFFF;
          if (fits && si + zi == sj) begin
            ext_size[i] = zi + zj;
            drop(j);
            j = i + 1;
          end else if (fits && sj + zj == si) begin
            ext_start[i] = sj;
            ext_size[i] = zi + zj;
            drop(j);
            j = i + 1;
          end else j++;
        end
      end
    endfunction

    function void note_request(in_req_t r);
      out_res_t e;
      int pick;
      bit found;
      e = '0;
      if (r.operation == OP_ALLOC) begin
        found = 0;
        pick = 0;
        for (int k = 0; k < n_ext; k++) begin
          if (ext_size[k] < r.block_size) continue;
          if (!found) begin
            pick = k;
            found = 1;
            if (policy != POL_BEST && policy != POL_WORST) break;
          end else if (policy == POL_BEST && ext_size[k] < ext_size[pick]) pick = k;
          else if (policy == POL_WORST && ext_size[k] > ext_size[pick]) pick = k;
        end
        if (!found) e.status = ST_NOFIT;
        else begin
          e.alloc_address = ext_start[pick][15:0];
          ext_start[pick] = {1'b0, ext_start[pick][15:0] + r.block_size};
          ext_size[pick] = ext_size[pick] - r.block_size;
          if (ext_size[pick] == 0) drop(pick);
        end
      end else if (r.block_size != 0) begin
        if (n_ext >= NEXT) e.status = ST_FULL;
        else begin
          ext_start[n_ext] = {1'b0, r.block_start};
          ext_size[n_ext] = {1'b0, r.block_size};
          n_ext++;
          merge_all();
        end
      end
      e.free_extents = n_ext[4:0];
      pending.push_back(e);
    endfunction

    function void check_result(out_res_t got);
      out_res_t e;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status || got.alloc_address !== e.alloc_address ||
          got.free_extents !== e.free_extents) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p actual %p", e, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  in_req_t in_req = '0;
  logic out_valid;
  out_res_t out_res;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  alloc_scoreboard sb;
  in_req_t live [$];
  int live_size [$];

  always #1 clk = ~clk;

  fit_policy_extent_allocator dut (.*);

  always @(posedge clk) if (rst_n && out_valid) sb.check_result(out_res);

  // start stays high after acceptance; the block is busy then, and the next
  // send with a nonzero gap or a drain lowers it
  task automatic send(in_req_t r);
    int gap;
    gap = $urandom_range(0, 4);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_req <= r;
    @(posedge clk iff !busy);
    sb.note_request(r);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    start <= 1'b0;
    while (sb.pending.size() != 0 && guard < 100000) begin
      @(posedge clk);
      guard++;
    end
    repeat (600) @(posedge clk);
  endtask

  task automatic write_cfg(logic [0:0] idx, logic [15:0] val);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.write_reg(idx, val);
    cfg_we <= 1'b0;
    repeat (3) @(posedge clk);
    live.delete();
    live_size.delete();
  endtask

  function automatic in_req_t mk(logic op, logic [15:0] sz, logic [15:0] st);
    in_req_t r;
    r.operation = op;
    r.block_size = sz;
    r.block_start = st;
    return r;
  endfunction

  task automatic alloc_track(logic [15:0] sz);
    out_res_t e;
    send(mk(OP_ALLOC, sz, 16'($urandom())));
    e = sb.pending[$];
    if (e.status == ST_OK && sz != 0) begin
      live.push_back(mk(OP_FREE, sz, e.alloc_address));
      live_size.push_back(sz);
    end
  endtask

  task automatic random_phase(int n, int maxsz);
    int pick;
    int c;
    for (int i = 0; i < n; i++) begin
      c = $urandom_range(0, 99);
      if (c < 45) alloc_track(16'($urandom_range(1, maxsz)));
      else if (c < 85 && live.size() != 0) begin
        pick = $urandom_range(0, live.size() - 1);
        send(live[pick]);
        live.delete(pick);
        live_size.delete(pick);
      end else if (c < 92) send(mk(OP_FREE, 16'($urandom()), 16'($urandom())));
      else if (c < 96) send(mk(OP_ALLOC, 16'($urandom()), 16'($urandom())));
      else send(mk(c[0], 16'd0, 16'($urandom())));
    end
  endtask

  initial begin
    #10000000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    sb = new();
    sb.reset_state();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    repeat (3) @(posedge clk);

    // directed
    send(mk(OP_ALLOC, 16'd0, 16'hFFFF));
    send(mk(OP_ALLOC, 16'd100, 16'd0));
    send(mk(OP_ALLOC, 16'hFFFF, 16'd0));
    send(mk(OP_FREE, 16'd0, 16'd5));
    send(mk(OP_FREE, 16'd100, 16'd0));
    send(mk(OP_FREE, 16'd10, 16'd5000));
    send(mk(OP_ALLOC, 16'd4096, 16'd0));
    for (int k = 0; k < 17; k++) send(mk(OP_FREE, 16'd1, 16'(6000 + 2 * k)));
    write_cfg(REG_POOL_SIZE, 16'd0);
    send(mk(OP_ALLOC, 16'd0, 16'd0));
    send(mk(OP_FREE, 16'hFFFF, 16'hFFFF));
    send(mk(OP_FREE, 16'd1, 16'd0));
    send(mk(OP_ALLOC, 16'd1, 16'd0));
    write_cfg(REG_POOL_SIZE, 16'hFFFF);
    send(mk(OP_ALLOC, 16'hFFFF, 16'd0));
    write_cfg(REG_FIT_POLICY, 16'd3);

    for (int ph = 0; ph < 8; ph++) begin
      write_cfg(REG_FIT_POLICY, 16'(ph % 4));
      case (ph)
        0: write_cfg(REG_POOL_SIZE, 16'd1);
        1: write_cfg(REG_POOL_SIZE, 16'hFFFF);
        2: write_cfg(REG_POOL_SIZE, 16'd4096);
        default: write_cfg(REG_POOL_SIZE, 16'($urandom_range(1, 65535)));
      endcase
      random_phase(75, (ph == 0) ? 2 : 600);
      drain();
      random_phase(75, 3000);
    end
    write_cfg(REG_FIT_POLICY, 16'(POL_BEST));
    drain();
    cfg_we <= 1'b0;

    drain();
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule

FILE: filelist.f
sv/fpea_pkg.sv
sv/fpea_dp.sv
sv/fpea_ctrl.sv
sv/fit_policy_extent_allocator.sv
tb/fit_policy_extent_allocator_test.sv
